@@ design/i2cmbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Phase codes, operation codes and reset constants shared by the sequencer.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    // Sequencer phase, one step of an SCL/SDA sequence per tick
    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S1   = 5'd1,
        PH_S2   = 5'd2,
        PH_S3   = 5'd3,
        PH_S4   = 5'd4,
        PH_P1   = 5'd5,
        PH_P2   = 5'd6,
        PH_P3   = 5'd7,
        PH_WD   = 5'd8,
        PH_WH   = 5'd9,
        PH_WL   = 5'd10,
        PH_WR1  = 5'd11,
        PH_WR2  = 5'd12,
        PH_AR   = 5'd13,
        PH_AH   = 5'd14,
        PH_AW   = 5'd15,
        PH_RL   = 5'd16,
        PH_RH   = 5'd17,
        PH_RA   = 5'd18,
        PH_RAH  = 5'd19,
        PH_RAL  = 5'd20
    } phase_t;

    // Command codes carried by each tick
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    localparam int          TIMEOUT_W         = 10;
    localparam int          BYTE_W            = 8;
    localparam int          BITCNT_W          = 4;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 10'd250;
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE     = 4'd8;

endpackage

@@ design/i2c_master_bit_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Steps through start, stop, write-byte and read-byte line sequences, one
// step per timing tick, and reports line levels and status per tick.
// ----------------------------------------------------------------------------
// Every input transaction is one bus tick and produces exactly one result
// transaction. The core accepts one tick per clock while out_ready keeps the
// result channel from stalling: the tick is registered, and when it fires the
// sequencer state is stepped and the result is registered for the output.
// The rate is bounded by the single sequencer state update per clock. A
// command (start, write, read, stop) is taken only while the sequencer is
// idle; commands arriving while busy and unused operation codes are ignored.
// ack_timeout may be rewritten only while no tick is in flight.
module i2c_master_bit_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    // tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        sda_sample,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_failed,
    // configuration
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);

    // Configuration register
    logic [i2cmbs_pkg::TIMEOUT_W-1:0] ack_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_timeout_reg <= i2cmbs_pkg::ACK_TIMEOUT_RESET;
        else if (cfg_we)
            ack_timeout_reg <= cfg_wdata;
    end

    // Input stage
    logic                              in_vld_reg;
    logic [2:0]                        op_reg;
    logic [i2cmbs_pkg::BYTE_W-1:0]     tx_byte_reg;
    logic                              send_ack_reg;
    logic                              sda_in_reg;
    logic                              out_vld_reg;
    logic                              advance;
    logic                              fire;

    assign advance  = !out_vld_reg || out_ready;
    assign fire     = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg       <= operation;
            tx_byte_reg  <= tx_byte;
            send_ack_reg <= send_ack;
            sda_in_reg   <= sda_sample;
        end
    end

    // Sequencer state
    i2cmbs_pkg::phase_t                 phase_reg, phase_next;
    logic [i2cmbs_pkg::BITCNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [i2cmbs_pkg::BYTE_W-1:0]      shift_reg, shift_next;
    logic [i2cmbs_pkg::TIMEOUT_W-1:0]   wait_cnt_reg, wait_cnt_next;
    logic                               ack_reply_reg, ack_reply_next;
    logic                               scl_reg, scl_next;
    logic                               sda_reg, sda_next;
    logic [i2cmbs_pkg::BYTE_W-1:0]      rx_hold_reg, rx_hold_next;
    logic                               fail_reg, fail_next;
    logic                               done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cmbs_pkg::PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            wait_cnt_reg  <= '0;
            ack_reply_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_hold_reg   <= '0;
            fail_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            wait_cnt_reg  <= wait_cnt_next;
            ack_reply_reg <= ack_reply_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            rx_hold_reg   <= rx_hold_next;
            fail_reg      <= fail_next;
        end
    end

    // Next state: command launch, then the step of the current phase
    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        wait_cnt_next  = wait_cnt_reg;
        ack_reply_next = ack_reply_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rx_hold_next   = rx_hold_reg;
        fail_next      = fail_reg;
        done_next      = 1'b0;

        // launch a command only when idle
        if (phase_reg == i2cmbs_pkg::PH_IDLE)
        begin
            unique case (op_reg)
                i2cmbs_pkg::OP_START:
                begin
                    fail_next = 1'b0; bit_cnt_next = '0; wait_cnt_next = '0;
                    phase_next = i2cmbs_pkg::PH_S1;
                end
                i2cmbs_pkg::OP_WRITE:
                begin
                    fail_next = 1'b0; bit_cnt_next = '0; wait_cnt_next = '0;
                    shift_next = tx_byte_reg;
                    phase_next = i2cmbs_pkg::PH_WD;
                end
                i2cmbs_pkg::OP_READ:
                begin
                    fail_next = 1'b0; bit_cnt_next = '0; wait_cnt_next = '0;
                    shift_next     = '0;
                    ack_reply_next = send_ack_reg;
                    sda_next       = 1'b1;
                    phase_next     = i2cmbs_pkg::PH_RL;
                end
                i2cmbs_pkg::OP_STOP:
                begin
                    fail_next = 1'b0; bit_cnt_next = '0; wait_cnt_next = '0;
                    phase_next = i2cmbs_pkg::PH_P1;
                end
                default: ;
            endcase
        end

        // one sequence step
        unique case (phase_next)
            i2cmbs_pkg::PH_IDLE: ;
            i2cmbs_pkg::PH_S1: begin sda_next = 1'b1; phase_next = i2cmbs_pkg::PH_S2; end
            i2cmbs_pkg::PH_S2: begin scl_next = 1'b1; phase_next = i2cmbs_pkg::PH_S3; end
            i2cmbs_pkg::PH_S3: begin sda_next = 1'b0; phase_next = i2cmbs_pkg::PH_S4; end
            i2cmbs_pkg::PH_S4:
            begin
                scl_next = 1'b0; phase_next = i2cmbs_pkg::PH_IDLE; done_next = 1'b1;
            end
            i2cmbs_pkg::PH_P1: begin sda_next = 1'b0; phase_next = i2cmbs_pkg::PH_P2; end
            i2cmbs_pkg::PH_P2: begin scl_next = 1'b1; phase_next = i2cmbs_pkg::PH_P3; end
            i2cmbs_pkg::PH_P3:
            begin
                sda_next = 1'b1; phase_next = i2cmbs_pkg::PH_IDLE; done_next = 1'b1;
            end
            // write: shift out MSB first
            i2cmbs_pkg::PH_WD:
            begin
                scl_next   = 1'b0;
                sda_next   = shift_next[i2cmbs_pkg::BYTE_W-1];
                shift_next = {shift_next[i2cmbs_pkg::BYTE_W-2:0], 1'b0};
                phase_next = i2cmbs_pkg::PH_WH;
            end
            i2cmbs_pkg::PH_WH: begin scl_next = 1'b1; phase_next = i2cmbs_pkg::PH_WL; end
            i2cmbs_pkg::PH_WL:
            begin
                scl_next     = 1'b0;
                bit_cnt_next = bit_cnt_next + 1'b1;
                phase_next   = (bit_cnt_next >= i2cmbs_pkg::BITS_PER_BYTE) ?
                               i2cmbs_pkg::PH_WR1 : i2cmbs_pkg::PH_WD;
            end
            i2cmbs_pkg::PH_WR1: begin sda_next = 1'b1; phase_next = i2cmbs_pkg::PH_WR2; end
            i2cmbs_pkg::PH_WR2: begin scl_next = 1'b0; phase_next = i2cmbs_pkg::PH_AR; end
            i2cmbs_pkg::PH_AR:
            begin
                sda_next = 1'b1; wait_cnt_next = '0; phase_next = i2cmbs_pkg::PH_AH;
            end
            i2cmbs_pkg::PH_AH: begin scl_next = 1'b1; phase_next = i2cmbs_pkg::PH_AW; end
            // acknowledge wait with timeout; a timeout falls into the stop sequence
            i2cmbs_pkg::PH_AW:
            begin
                priority if (!sda_in_reg)
                begin
                    scl_next = 1'b0; phase_next = i2cmbs_pkg::PH_IDLE; done_next = 1'b1;
                end
                else if (wait_cnt_next >= ack_timeout_reg)
                begin
                    fail_next = 1'b1; sda_next = 1'b0; phase_next = i2cmbs_pkg::PH_P2;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_next + 1'b1;
                end
            end
            // read: shift in MSB first on the high clock phase
            i2cmbs_pkg::PH_RL: begin scl_next = 1'b0; phase_next = i2cmbs_pkg::PH_RH; end
            i2cmbs_pkg::PH_RH:
            begin
                scl_next     = 1'b1;
                shift_next   = {shift_next[i2cmbs_pkg::BYTE_W-2:0], sda_in_reg};
                bit_cnt_next = bit_cnt_next + 1'b1;
                if (bit_cnt_next >= i2cmbs_pkg::BITS_PER_BYTE)
                begin
                    rx_hold_next = shift_next;
                    phase_next   = i2cmbs_pkg::PH_RA;
                end
                else
                begin
                    phase_next = i2cmbs_pkg::PH_RL;
                end
            end
            i2cmbs_pkg::PH_RA:
            begin
                scl_next = 1'b0; sda_next = !ack_reply_next; phase_next = i2cmbs_pkg::PH_RAH;
            end
            i2cmbs_pkg::PH_RAH: begin scl_next = 1'b1; phase_next = i2cmbs_pkg::PH_RAL; end
            i2cmbs_pkg::PH_RAL:
            begin
                scl_next = 1'b0; phase_next = i2cmbs_pkg::PH_IDLE; done_next = 1'b1;
            end
            default: phase_next = i2cmbs_pkg::PH_IDLE;
        endcase
    end

    // Result register
    logic                          scl_out_reg, sda_out_reg, busy_out_reg, done_out_reg;
    logic [i2cmbs_pkg::BYTE_W-1:0] rx_out_reg;
    logic                          fail_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (fire)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            scl_out_reg  <= scl_next;
            sda_out_reg  <= sda_next;
            busy_out_reg <= (phase_next != i2cmbs_pkg::PH_IDLE);
            done_out_reg <= done_next;
            rx_out_reg   <= rx_hold_next;
            fail_out_reg <= fail_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign scl_level  = scl_out_reg;
    assign sda_level  = sda_out_reg;
    assign busy_res   = busy_out_reg;
    assign done_res   = done_out_reg;
    assign rx_byte    = rx_out_reg;
    assign ack_failed = fail_out_reg;

    // Assertions
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(done_out_reg && busy_out_reg))
        else $error("done and busy reported together");

    a_fail_enters_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fail_reg) |-> (phase_reg == i2cmbs_pkg::PH_P2))
        else $error("ack failure without stop sequence");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= i2cmbs_pkg::BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> in_vld_reg && $stable(op_reg))
        else $error("pending tick lost while output stalled");

endmodule
